FILE: rtl/htfc_pkg.sv
// ============================================================================
// htfc_pkg: shared types, constants and functions
// Holds the CRC-8 step, the divide-by-65535 helper and the frame byte slots.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package htfc_pkg;

    // CRC-8: polynomial 0x31, seed 0xFF, no final XOR, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte slots within the six-byte reply
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Conversion scale factors
    localparam logic [15:0] T_CENTI_SCALE = 16'd17500;
    localparam logic [15:0] H_CENTI_SCALE = 16'd10000;
    localparam logic [7:0]  T_WHOLE_SCALE = 8'd175;
    localparam logic [6:0]  H_WHOLE_SCALE = 7'd100;
    localparam logic [14:0] T_CENTI_OFFSET = 15'd4500;
    // 45 * 65535, offset of the exact temperature numerator
    localparam logic [24:0] T_WHOLE_OFFSET = 25'd2949075;
    // Half of the 65535 divisor, rounds the whole-unit values
    localparam logic [31:0] ROUND_HALF = 32'd32767;

    // One finished frame handed to the conversion stages
    typedef struct packed {
        logic        crc_ok;
        logic [15:0] temperature_raw;
        logic [15:0] humidity_raw;
    } frame_word_t;

    // One CRC-8 byte update, eight shift steps
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^31: x>>16 is low by at most one, and
    // the remainder against that estimate is x[15:0] + (x>>16).
    function automatic logic [15:0] div65535(input logic [31:0] x);
        logic [15:0] q0;
        logic [16:0] rem;
        q0  = x[31:16];
        rem = {1'b0, x[15:0]} + {1'b0, q0};
        return (rem >= 17'd65535) ? q0 + 16'd1 : q0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/humidity_temp_frame_checker.sv
// ============================================================================
// humidity_temp_frame_checker: CRC-checked sensor reply to engineering units
// Takes the six-byte reply byte by byte and gives one result per frame.
//
//   channel   valid/stall                  payload
//   byte      byte_valid / byte_stall      rx_byte, frame_start
//   result    result_valid / result_stall  temperature_centi, humidity_centi,
//                                          temperature_whole, humidity_whole,
//                                          crc_ok
//
// One byte per clock cycle, sustained while byte_stall is low.
// The result of a frame passes, after its sixth byte is taken, through the
// frame register, scaling register and result register.
// byte_stall rises only when all three of those registers are full and the
// result side stalls.
// Reset clears the byte count, the CRC to 0xFF and all valid flags.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output      logic               byte_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               frame_start,
    output      logic               result_valid,
    input  wire logic               result_stall,
    output      logic signed [14:0] temperature_centi,
    output      logic [13:0]        humidity_centi,
    output      logic signed [8:0]  temperature_whole,
    output      logic [6:0]         humidity_whole,
    output      logic               crc_ok
);

    logic                  word_valid;
    logic                  word_stall;
    htfc_pkg::frame_word_t word;
    logic                  byte_accept;

    // Byte side stalls only while the frame register cannot move on
    assign byte_stall  = word_valid && word_stall;
    assign byte_accept = byte_valid && !byte_stall;

    htfc_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word        (word)
    );

    htfc_convert u_convert (
        .clk               (clk),
        .rst_n             (rst_n),
        .word_valid        (word_valid),
        .word_stall        (word_stall),
        .word              (word),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .temperature_whole (temperature_whole),
        .humidity_whole    (humidity_whole),
        .crc_ok            (crc_ok)
    );

    // A failed frame reports all zeros
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !crc_ok) |->
            (temperature_centi == 15'sd0 && humidity_centi == 14'd0 &&
             temperature_whole == 9'sd0 && humidity_whole == 7'd0))
        else $error("failed frame with nonzero fields");

    // Byte side only stalls behind a full, stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (result_valid && result_stall))
        else $error("byte stall without result backpressure");

    // Converted values stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (humidity_whole <= 7'd100 && humidity_centi <= 14'd10000 &&
             temperature_whole >= -9'sd45 && temperature_whole <= 9'sd130))
        else $error("converted value out of range");

    // Whole temperature agrees with hundredths to within one degree
    a_whole_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((16'(temperature_whole) * 16'sd100 - 16'(temperature_centi) <= 16'sd100) &&
             (16'(temperature_centi) - 16'(temperature_whole) * 16'sd100 <= 16'sd100)))
        else $error("whole and centi temperature disagree");

endmodule

`default_nettype wire

FILE: rtl/htfc_frame.sv
// ============================================================================
// htfc_frame: reply frame tracker
// Counts bytes, runs the CRC per word and registers the finished frame.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module htfc_frame (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_accept,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                frame_start,
    output      logic                word_valid,
    input  wire logic                word_stall,
    output      htfc_pkg::frame_word_t word
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] t_raw_reg, t_raw_next;
    logic [7:0]  h_msb_reg, h_msb_next;
    logic [7:0]  h_lsb_reg, h_lsb_next;
    logic        t_good_reg, t_good_next;
    logic        word_valid_reg, word_valid_next;
    htfc_pkg::frame_word_t word_reg, word_next;

    logic        restart;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_base;
    logic [7:0]  crc_step;
    logic        last_byte;

    // Effective slot: a frame mark or a stray count starts over
    assign restart  = frame_start || (pos_reg > htfc_pkg::POS_H_CRC);
    assign pos_eff  = restart ? htfc_pkg::POS_T_MSB : pos_reg;
    assign crc_base = restart ? htfc_pkg::CRC_INIT : crc_reg;
    assign crc_step = htfc_pkg::crc8_update(crc_base, rx_byte);
    assign last_byte = byte_accept && (pos_eff == htfc_pkg::POS_H_CRC);

    // Per-byte state update
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        t_raw_next  = t_raw_reg;
        h_msb_next  = h_msb_reg;
        h_lsb_next  = h_lsb_reg;
        t_good_next = t_good_reg;
        if (byte_accept)
        begin
            pos_next = pos_eff + 3'd1;
            unique case (pos_eff)
                htfc_pkg::POS_T_MSB:
                begin
                    crc_next   = crc_step;
                    t_raw_next = {rx_byte, 8'h00};
                end
                htfc_pkg::POS_T_LSB:
                begin
                    crc_next   = crc_step;
                    t_raw_next = {t_raw_reg[15:8], rx_byte};
                end
                htfc_pkg::POS_T_CRC:
                begin
                    t_good_next = (rx_byte == crc_base);
                    crc_next    = htfc_pkg::CRC_INIT;
                end
                htfc_pkg::POS_H_MSB:
                begin
                    crc_next   = crc_step;
                    h_msb_next = rx_byte;
                end
                htfc_pkg::POS_H_LSB:
                begin
                    crc_next   = crc_step;
                    h_lsb_next = rx_byte;
                end
                htfc_pkg::POS_H_CRC:
                begin
                    pos_next = htfc_pkg::POS_T_MSB;
                    crc_next = htfc_pkg::CRC_INIT;
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // Finished-frame register, held while downstream stalls
    always_comb
    begin
        word_next       = word_reg;
        word_valid_next = word_valid_reg && word_stall;
        if (last_byte)
        begin
            word_valid_next           = 1'b1;
            word_next.crc_ok          = t_good_reg && (rx_byte == crc_base);
            word_next.temperature_raw = t_raw_reg;
            word_next.humidity_raw    = {h_msb_reg, h_lsb_reg};
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= htfc_pkg::POS_T_MSB;
            crc_reg        <= htfc_pkg::CRC_INIT;
            t_raw_reg      <= 16'h0000;
            h_msb_reg      <= 8'h00;
            h_lsb_reg      <= 8'h00;
            t_good_reg     <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            t_raw_reg      <= t_raw_next;
            h_msb_reg      <= h_msb_next;
            h_lsb_reg      <= h_lsb_next;
            t_good_reg     <= t_good_next;
            word_valid_reg <= word_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

FILE: rtl/htfc_convert.sv
// ============================================================================
// htfc_convert: raw-to-engineering-unit conversion
// Two stages: constant scaling, then divide by 65535 with offset and rounding.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module htfc_convert (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  word_valid,
    output      logic                  word_stall,
    input  wire htfc_pkg::frame_word_t word,
    output      logic                  result_valid,
    input  wire logic                  result_stall,
    output      logic signed [14:0]    temperature_centi,
    output      logic [13:0]           humidity_centi,
    output      logic signed [8:0]     temperature_whole,
    output      logic [6:0]            humidity_whole,
    output      logic                  crc_ok
);

    // Stage 2: scaled products
    logic               s2_valid_reg;
    logic               s2_ok_reg;
    logic [30:0]        s2_t_prod_reg;
    logic [29:0]        s2_h_prod_reg;
    logic signed [24:0] s2_t_num_reg;
    logic [22:0]        s2_h_num_reg;

    logic [23:0]        t_x175;
    logic signed [24:0] t_num_next;

    // Stage 3: result register
    logic               s3_valid_reg;
    logic signed [14:0] s3_tc_reg, s3_tc_next;
    logic [13:0]        s3_hc_reg, s3_hc_next;
    logic signed [8:0]  s3_tw_reg, s3_tw_next;
    logic [6:0]         s3_hw_reg, s3_hw_next;
    logic               s3_ok_reg;

    logic               s3_ready;
    logic               s2_ready;

    logic [15:0]        tc_quot;
    logic [15:0]        hc_quot;
    logic [23:0]        t_mag;
    logic [15:0]        tw_quot;
    logic [15:0]        hw_quot;

    // Stall chain: a stage loads when empty or when its contents move on
    assign s3_ready   = !s3_valid_reg || !result_stall;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign word_stall = !s2_ready;

    // Stage 2 math: one constant multiply per path
    assign t_x175     = 24'(32'(word.temperature_raw) * 32'(htfc_pkg::T_WHOLE_SCALE));
    assign t_num_next = $signed({1'b0, t_x175}) - $signed(htfc_pkg::T_WHOLE_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= word_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && word_valid)
        begin
            s2_ok_reg     <= word.crc_ok;
            s2_t_prod_reg <= 31'(32'(word.temperature_raw) * 32'(htfc_pkg::T_CENTI_SCALE));
            s2_h_prod_reg <= 30'(32'(word.humidity_raw) * 32'(htfc_pkg::H_CENTI_SCALE));
            s2_t_num_reg  <= t_num_next;
            s2_h_num_reg  <= 23'(32'(word.humidity_raw) * 32'(htfc_pkg::H_WHOLE_SCALE)
                                 + htfc_pkg::ROUND_HALF);
        end
    end

    // Stage 3 math: divide by 65535, offset, sign, zero on CRC failure
    assign tc_quot = htfc_pkg::div65535({1'b0, s2_t_prod_reg});
    assign hc_quot = htfc_pkg::div65535({2'b00, s2_h_prod_reg});
    assign t_mag   = s2_t_num_reg[24] ? 24'(-s2_t_num_reg) : s2_t_num_reg[23:0];
    assign tw_quot = htfc_pkg::div65535(32'(t_mag) + htfc_pkg::ROUND_HALF);
    assign hw_quot = htfc_pkg::div65535(32'(s2_h_num_reg));

    always_comb
    begin
        s3_tc_next = '0;
        s3_hc_next = '0;
        s3_tw_next = '0;
        s3_hw_next = '0;
        if (s2_ok_reg)
        begin
            s3_tc_next = $signed(15'(tc_quot) - htfc_pkg::T_CENTI_OFFSET);
            s3_hc_next = 14'(hc_quot);
            s3_tw_next = s2_t_num_reg[24] ? -$signed(9'(tw_quot)) : $signed(9'(tw_quot));
            s3_hw_next = 7'(hw_quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_tc_reg <= s3_tc_next;
            s3_hc_reg <= s3_hc_next;
            s3_tw_reg <= s3_tw_next;
            s3_hw_reg <= s3_hw_next;
            s3_ok_reg <= s2_ok_reg;
        end
    end

    assign result_valid      = s3_valid_reg;
    assign temperature_centi = s3_tc_reg;
    assign humidity_centi    = s3_hc_reg;
    assign temperature_whole = s3_tw_reg;
    assign humidity_whole    = s3_hw_reg;
    assign crc_ok            = s3_ok_reg;

endmodule

`default_nettype wire
